>>> sv/pdi_frame_transceiver_assert.svh
// Assertion macros for the frame transceiver. The checks are compiled out
// when SYNTHESIS is defined.
`ifndef PDI_FRAME_TRANSCEIVER_ASSERT_SVH
`define PDI_FRAME_TRANSCEIVER_ASSERT_SVH

`ifndef SYNTHESIS
`define PDI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdi_frame_transceiver: same-cycle check failed");
`define PDI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdi_frame_transceiver: next-cycle check failed");
`else
`define PDI_ASSERT_SAME(label, ante, cons)
`define PDI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/pdi_pkg.sv
`default_nettype none

package pdi_pkg;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SEND = 2'd1;
  localparam logic [1:0] KIND_RECV = 2'd2;

  localparam logic [8:0] RX_TIMEOUT_RESET = 9'd256;

  // Bit positions inside a frame.
  localparam logic [3:0] BIT_LAST_DATA = 4'd8;
  localparam logic [3:0] BIT_PARITY    = 4'd9;
  localparam logic [3:0] BIT_RX_LAST   = 4'd10;
  localparam logic [3:0] BIT_TX_LAST   = 4'd11;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       data_in;
  } in_item_t;

  typedef struct packed {
    logic       data_out;
    logic       data_drive;
    logic       clock_active;
    logic       busy_res;
    logic       rx_done;
    logic [7:0] rx_byte;
    logic       parity_error;
    logic       stop_error;
    logic       timeout_error;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/pdi_frame_transceiver.sv
// Channel   Direction  Payload     Handshake
// in_       input      in_item_t   in_valid / in_ready
// out_      output     out_item_t  out_valid / out_ready
// cfg_      input      9 bits      cfg_we, no wait
//
// Every transfer in yields one transfer out, via the input register and the
// result register; one item per cycle is sustained while out_ready is high.
// The frame state advances once per item, in the cycle the item moves from
// the input register into the result register. A stalled output holds the
// result register; the input register holds one more, then in_ready drops.
// Reset is synchronous: line released, block idle, rx_timeout back to 256.
`default_nettype none
`include "pdi_frame_transceiver_assert.svh"

module pdi_frame_transceiver import pdi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_item,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata
);

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic [8:0] rx_timeout_r;
  logic       advance;
  out_item_t  step_res;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  pdi_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .item       (in_item_r),
    .rx_timeout (rx_timeout_r),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      rx_timeout_r <= RX_TIMEOUT_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        rx_timeout_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= step_res;
    end
  end

  `PDI_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_r)
  `PDI_ASSERT_SAME(a_done_is_receive, out_valid && out_item.rx_done, out_item.clock_active && out_item.busy_res && !out_item.data_drive)
  `PDI_ASSERT_SAME(a_timeout_empty, out_valid && out_item.timeout_error, out_item.rx_done && (out_item.rx_byte == 8'd0))
  `PDI_ASSERT_SAME(a_idle_quiet, out_valid && !out_item.busy_res, !out_item.clock_active && (out_item.data_out == out_item.data_drive))

endmodule

`default_nettype wire

>>> sv/pdi_step.sv
`default_nettype none

module pdi_step import pdi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire in_item_t   item,
  input  wire logic [8:0] rx_timeout,
  output out_item_t       res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TX,
    PH_RX_WAIT,
    PH_RX_FRAME
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_count_r, bit_count_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       parity_r, parity_nxt;
  logic [8:0] wait_count_r, wait_count_nxt;
  logic       line_driven_r, line_driven_nxt;
  logic       first_stop_r, first_stop_nxt;

  logic       do_tx;
  logic       do_wait;
  logic [8:0] wait_base;
  logic [8:0] wait_inc;
  logic [3:0] tx_idx;
  logic       tx_bit;

  always_comb begin
    phase_nxt       = phase_r;
    bit_count_nxt   = bit_count_r;
    shift_nxt       = shift_r;
    parity_nxt      = parity_r;
    wait_count_nxt  = wait_count_r;
    line_driven_nxt = line_driven_r;
    first_stop_nxt  = first_stop_r;
    res             = '0;
    do_tx           = 1'b0;
    do_wait         = 1'b0;
    wait_base       = wait_count_r;
    tx_idx          = bit_count_r - 4'd1;
    tx_bit          = 1'b1;
    wait_inc        = '0;

    unique case (phase_r)
      PH_TX: begin
        do_tx = 1'b1;
      end
      PH_RX_WAIT: begin
        do_wait = 1'b1;
      end
      PH_RX_FRAME: begin
        res.clock_active = 1'b1;
        res.busy_res     = 1'b1;
        if (bit_count_r >= BIT_RX_LAST) begin
          phase_nxt          = PH_IDLE;
          bit_count_nxt      = '0;
          res.rx_done        = 1'b1;
          res.rx_byte        = shift_r;
          res.parity_error   = parity_r;
          res.stop_error     = ~(first_stop_r & item.data_in);
        end else begin
          if (bit_count_r < BIT_LAST_DATA) begin
            shift_nxt  = {item.data_in, shift_r[7:1]};
            parity_nxt = parity_r ^ item.data_in;
          end else if (bit_count_r == BIT_LAST_DATA) begin
            parity_nxt = parity_r ^ item.data_in;
          end else begin
            first_stop_nxt = item.data_in;
          end
          bit_count_nxt = bit_count_r + 4'd1;
        end
      end
      PH_IDLE: begin
        if (item.kind == KIND_SEND) begin
          shift_nxt     = item.tx_byte;
          parity_nxt    = 1'b0;
          phase_nxt     = PH_TX;
          res.clock_active = 1'b1;
          res.busy_res     = 1'b1;
          if (!line_driven_r) begin
            // Idle bit of 1 while the line is still released.
            line_driven_nxt = 1'b1;
            bit_count_nxt   = '0;
            res.data_out    = 1'b1;
          end else begin
            // Start bit goes out in the command cycle itself.
            bit_count_nxt  = 4'd1;
            res.data_out   = 1'b0;
            res.data_drive = 1'b1;
          end
        end else if (item.kind == KIND_RECV) begin
          wait_count_nxt = '0;
          phase_nxt      = PH_RX_WAIT;
          if (line_driven_r) begin
            // Turnaround cycle after releasing the line.
            line_driven_nxt  = 1'b0;
            res.clock_active = 1'b1;
            res.busy_res     = 1'b1;
          end else begin
            do_wait   = 1'b1;
            wait_base = '0;
          end
        end else begin
          res.data_out   = line_driven_r;
          res.data_drive = line_driven_r;
        end
      end
      default: begin
      end
    endcase

    if (do_tx) begin
      res.data_drive   = 1'b1;
      res.clock_active = 1'b1;
      res.busy_res     = 1'b1;
      if (bit_count_r == '0) begin
        tx_bit = 1'b0;
      end else if (bit_count_r <= BIT_LAST_DATA) begin
        tx_bit     = shift_r[tx_idx[2:0]];
        parity_nxt = parity_r ^ tx_bit;
      end else if (bit_count_r == BIT_PARITY) begin
        tx_bit = parity_r;
      end else begin
        tx_bit = 1'b1;
      end
      res.data_out = tx_bit;
      if (bit_count_r >= BIT_TX_LAST) begin
        phase_nxt     = PH_IDLE;
        bit_count_nxt = '0;
      end else begin
        bit_count_nxt = bit_count_r + 4'd1;
      end
    end

    if (do_wait) begin
      res.clock_active = 1'b1;
      res.busy_res     = 1'b1;
      wait_inc         = wait_base + 9'd1;
      if (!item.data_in) begin
        phase_nxt      = PH_RX_FRAME;
        bit_count_nxt  = '0;
        shift_nxt      = '0;
        parity_nxt     = 1'b0;
        wait_count_nxt = wait_base;
      end else if (wait_inc >= rx_timeout) begin
        phase_nxt         = PH_IDLE;
        wait_count_nxt    = '0;
        res.rx_done       = 1'b1;
        res.timeout_error = 1'b1;
      end else begin
        wait_count_nxt = wait_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_count_r   <= '0;
      shift_r       <= '0;
      parity_r      <= 1'b0;
      wait_count_r  <= '0;
      line_driven_r <= 1'b0;
      first_stop_r  <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      bit_count_r   <= bit_count_nxt;
      shift_r       <= shift_nxt;
      parity_r      <= parity_nxt;
      wait_count_r  <= wait_count_nxt;
      line_driven_r <= line_driven_nxt;
      first_stop_r  <= first_stop_nxt;
    end
  end

endmodule

`default_nettype wire

>>> tb/pdi_frame_checker.sv
`timescale 1ns / 100ps

module pdi_frame_checker import pdi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  output int unsigned pending,
  output logic        link_idle,
  output int unsigned fails
);

  typedef enum logic [1:0] {LINK_IDLE, LINK_SEND, LINK_HUNT, LINK_FRAME} link_state_t;

  link_state_t link_state;
  logic [3:0]  bit_idx;
  logic [7:0]  shifter;
  logic        parity_acc;
  logic [8:0]  hunt_count;
  logic        line_owned;
  logic        stop_first;
  logic [8:0]  start_timeout;

  out_item_t   line_results_q[$];

  function automatic out_item_t clocked_cycle();
    out_item_t r;
    r = '0;
    r.clock_active = 1'b1;
    r.busy_res = 1'b1;
    return r;
  endfunction

  function automatic out_item_t send_bit();
    out_item_t  r;
    logic       b;
    logic [3:0] pos;
    r = clocked_cycle();
    pos = bit_idx - 4'd1;
    if (bit_idx == 4'd0) begin
      b = 1'b0;
    end else if (bit_idx <= BIT_LAST_DATA) begin
      b = shifter[pos[2:0]];
      parity_acc ^= b;
    end else if (bit_idx == BIT_PARITY) begin
      b = parity_acc;
    end else begin
      b = 1'b1;
    end
    if (bit_idx >= BIT_TX_LAST) begin
      link_state = LINK_IDLE;
      bit_idx = 4'd0;
    end else begin
      bit_idx = bit_idx + 4'd1;
    end
    r.data_out = b;
    r.data_drive = 1'b1;
    return r;
  endfunction

  function automatic out_item_t hunt_bit(input logic din);
    out_item_t r;
    r = clocked_cycle();
    if (!din) begin
      link_state = LINK_FRAME;
      bit_idx = 4'd0;
      shifter = 8'd0;
      parity_acc = 1'b0;
    end else begin
      hunt_count = hunt_count + 9'd1;
      if (hunt_count >= start_timeout) begin
        link_state = LINK_IDLE;
        hunt_count = 9'd0;
        r.rx_done = 1'b1;
        r.timeout_error = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic out_item_t frame_bit(input logic din);
    out_item_t r;
    r = clocked_cycle();
    if (bit_idx >= BIT_RX_LAST) begin
      r.rx_done = 1'b1;
      r.rx_byte = shifter;
      r.parity_error = parity_acc;
      r.stop_error = !(stop_first && din);
      link_state = LINK_IDLE;
      bit_idx = 4'd0;
    end else begin
      if (bit_idx < BIT_LAST_DATA) begin
        shifter = {din, shifter[7:1]};
        parity_acc ^= din;
      end else if (bit_idx == BIT_LAST_DATA) begin
        parity_acc ^= din;
      end else begin
        stop_first = din;
      end
      bit_idx = bit_idx + 4'd1;
    end
    return r;
  endfunction

  function automatic out_item_t predict_line_cycle(input in_item_t it);
    out_item_t r;
    r = '0;
    case (link_state)
      LINK_SEND:  return send_bit();
      LINK_HUNT:  return hunt_bit(it.data_in);
      LINK_FRAME: return frame_bit(it.data_in);
      default: ;
    endcase
    if (it.kind == KIND_SEND) begin
      shifter = it.tx_byte;
      parity_acc = 1'b0;
      bit_idx = 4'd0;
      link_state = LINK_SEND;
      if (!line_owned) begin
        // The idle bit goes out with the line still released.
        line_owned = 1'b1;
        r = clocked_cycle();
        r.data_out = 1'b1;
        return r;
      end
      return send_bit();
    end
    if (it.kind == KIND_RECV) begin
      hunt_count = 9'd0;
      link_state = LINK_HUNT;
      if (line_owned) begin
        line_owned = 1'b0;
        return clocked_cycle();
      end
      return hunt_bit(it.data_in);
    end
    r.data_out = line_owned;
    r.data_drive = line_owned;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      link_state = LINK_IDLE;
      bit_idx = 4'd0;
      shifter = 8'd0;
      parity_acc = 1'b0;
      hunt_count = 9'd0;
      line_owned = 1'b0;
      stop_first = 1'b0;
      start_timeout = RX_TIMEOUT_RESET;
      line_results_q.delete();
      fails = 0;
    end else begin
      if (cfg_we)
        start_timeout = cfg_wdata;
      if (out_valid && out_ready) begin
        if (line_results_q.size() == 0) begin
          $error("result transfer with no expected result pending");
          fails++;
        end else begin
          want = line_results_q.pop_front();
          check_field("data_out", 8'(want.data_out), 8'(out_item.data_out));
          check_field("data_drive", 8'(want.data_drive), 8'(out_item.data_drive));
          check_field("clock_active", 8'(want.clock_active), 8'(out_item.clock_active));
          check_field("busy_res", 8'(want.busy_res), 8'(out_item.busy_res));
          check_field("rx_done", 8'(want.rx_done), 8'(out_item.rx_done));
          check_field("rx_byte", want.rx_byte, out_item.rx_byte);
          check_field("parity_error", 8'(want.parity_error), 8'(out_item.parity_error));
          check_field("stop_error", 8'(want.stop_error), 8'(out_item.stop_error));
          check_field("timeout_error", 8'(want.timeout_error),
                      8'(out_item.timeout_error));
        end
      end
      if (in_valid && in_ready)
        line_results_q.push_back(predict_line_cycle(in_item));
    end
    pending = line_results_q.size();
    link_idle = (link_state == LINK_IDLE);
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb import pdi_pkg::*; ();

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = 9'd0;

  int unsigned check_pending;
  logic        check_idle;
  int unsigned check_fails;

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned ready_run = 0;
  bit          ready_level = 1'b0;
  int unsigned cycle_count = 0;
  logic [8:0]  cur_timeout = RX_TIMEOUT_RESET;

  pdi_frame_transceiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pdi_frame_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pending   (check_pending),
    .link_idle (check_idle),
    .fails     (check_fails)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pdi_frame_transceiver regression: fail");
      $finish;
    end
  end

  // The receiver alternates long ready stretches, hard stalls and choppy runs.
  always @(negedge clk) begin
    if (ready_run == 0) begin
      case ($urandom_range(3))
        0: begin
          ready_level = 1'b0;
          ready_run = $urandom_range(1, 6);
        end
        1: begin
          ready_level = 1'b1;
          ready_run = $urandom_range(30, 90);
        end
        default: begin
          ready_level = 1'($urandom_range(1));
          ready_run = $urandom_range(1, 4);
        end
      endcase
    end
    ready_run--;
    out_ready <= ready_level;
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] tx_byte, input logic din);
    int unsigned gap;
    in_item_t    it;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    it.kind = kind;
    it.tx_byte = tx_byte;
    it.data_in = din;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [1:0] follow_kind(input bit noisy);
    if (noisy && $urandom_range(5) == 0)
      return 2'($urandom_range(3));
    return KIND_TICK;
  endfunction

  task automatic send_frame(input logic [7:0] b, input bit noisy);
    send_item(KIND_SEND, b, 1'($urandom_range(1)));
    // Twelve trailing items cover all frame bits, also after an idle bit.
    for (int i = 0; i < 12; i++)
      send_item(i < 10 ? follow_kind(noisy) : KIND_TICK, 8'($urandom_range(255)),
                1'($urandom_range(1)));
  endtask

  task automatic receive_frame(input logic [7:0] b, input int unsigned pre, input bit bad_par,
                               input bit stop_a, input bit stop_b, input bit noisy);
    logic [11:0] line_bits;
    line_bits = {stop_b, stop_a, ^b ^ bad_par, b, 1'b0};
    send_item(KIND_RECV, 8'($urandom_range(255)), 1'b1);
    repeat (pre) send_item(KIND_TICK, 8'($urandom_range(255)), 1'b1);
    for (int i = 0; i < 12; i++)
      send_item(i < 11 ? follow_kind(noisy) : KIND_TICK, 8'($urandom_range(255)),
                line_bits[i]);
  endtask

  // Brings the block back to idle with no transfer outstanding.
  task automatic settle();
    forever begin
      @(negedge clk);
      in_valid <= 1'b0;
      if (check_pending == 0 && check_idle)
        break;
      if (check_pending == 0)
        send_item(KIND_TICK, 8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic write_timeout(input logic [8:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_timeout = value;
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned pre;
    int unsigned eff;
    stop_at = items_sent + quota;
    eff = (cur_timeout == 0) ? 1 : cur_timeout;
    while (items_sent < stop_at) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        send_frame(8'($urandom_range(255)), $urandom_range(3) == 0);
      end else if (pick < 8) begin
        // Waits past the timeout only where the timeout is short.
        pre = (eff <= 64 && $urandom_range(9) == 0) ? eff + $urandom_range(2)
                                                     : $urandom_range(3);
        receive_frame(8'($urandom_range(255)), pre, $urandom_range(5) == 0,
                      $urandom_range(7) != 0, $urandom_range(7) != 0,
                      $urandom_range(3) == 0);
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all-ones send with commands arriving while busy, then a
    // receive after turnaround with bad parity and a low first stop bit.
    send_item(KIND_SEND, 8'hFF, 1'b0);
    send_item(KIND_RECV, 8'h00, 1'b1);
    send_item(KIND_UNUSED, 8'h5A, 1'b0);
    send_item(KIND_SEND, 8'h00, 1'b1);
    repeat (9) send_item(KIND_TICK, 8'hFF, 1'b1);
    receive_frame(8'h00, 0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_item(KIND_UNUSED, 8'hFF, 1'b1);

    random_phase(100);
    write_timeout(9'd1);
    random_phase(100);
    write_timeout(9'd0);
    random_phase(100);
    write_timeout(9'd511);
    // One receive that runs all the way to the longest timeout.
    receive_frame(8'($urandom_range(255)), 511, 1'b0, 1'b1, 1'b1, 1'b0);
    random_phase(100);
    write_timeout(9'd2);
    random_phase(100);
    write_timeout(9'($urandom_range(3, 40)));
    random_phase(100);
    write_timeout(RX_TIMEOUT_RESET);
    random_phase(100);
    write_timeout(9'($urandom_range(511)));
    random_phase(100);

    do begin
      @(negedge clk);
      in_valid <= 1'b0;
    end while (check_pending != 0);
    repeat (8) @(posedge clk);
    if (check_fails == 0)
      $display("pdi_frame_transceiver regression: pass");
    else
      $display("pdi_frame_transceiver regression: fail");
    $finish;
  end

endmodule
